// ===== hw/rtl/vns_pkg.sv =====
// Package for the vertex normal averaging block: widths, codes, controller states.
// No dependencies; every other file but vns_ram imports it.
package vns_pkg;

  localparam int MaxVertices = 1024;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int PosW        = 24;
  localparam int AccW        = 26;
  localparam int NrmW        = 16;
  localparam int EdgeW       = PosW + 1;
  localparam int CrsW        = 2 * EdgeW + 1;
  localparam int MagW        = 31;
  localparam int SumW        = 62;
  localparam int RootW       = 31;
  localparam int QuoW        = 15;

  localparam logic [NrmW-1:0] OneQ14 = NrmW'(16384);
  localparam logic signed [AccW-1:0] AccMax = AccW'(33554431);
  localparam logic signed [AccW-1:0] AccMin = -AccW'(33554432);

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_TRI  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_EDGE,
    ST_SHRINK,
    ST_CROSS,
    ST_CROSS2,
    ST_ACC_RD,
    ST_ACC_LAT,
    ST_SPLIT,
    ST_SCALE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIV,
    ST_ACC_UPD,
    ST_ACC_WR,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic [1:0] pos_sel;     // 0 reads a, 1 reads b, 2 reads c
    logic       pos_rd;
    logic       pos_wr;
    logic       latch_a;
    logic       latch_b;
    logic       latch_c;
    logic       edge_form;
    logic       shrink;
    logic       cross1;
    logic       cross2;
    logic       vec_from_acc;
    logic       acc_rd;
    logic       split;
    logic       scale;
    logic       square;
    logic       sum;
    logic       root_start;
    logic       root_step;
    logic       div_start;
    logic       div_step;
    logic       acc_wr;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t      func;
    logic       edge_big;
    logic       vec_zero;
    logic       scale_done;
    logic       root_done;
    logic       div_done;
    logic [1:0] acc_slot;
  } sts_t;

endpackage

// ===== hw/rtl/vns_if.sv =====
// Valid/ready channel interfaces for the vertex normal averaging block.
// Depends on vns_pkg for field widths.
interface vns_in_if import vns_pkg::*; (input logic clk);
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic [IdxW-1:0]        vertex_a;
  logic [IdxW-1:0]        vertex_b;
  logic [IdxW-1:0]        vertex_c;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  modport source (output valid, func, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, func, vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface vns_out_if import vns_pkg::*; (input logic clk);
  logic                   valid;
  logic                   ready;
  logic signed [NrmW-1:0] normal_x;
  logic signed [NrmW-1:0] normal_y;
  logic signed [NrmW-1:0] normal_z;
  logic                   zero_normal;
  modport source (output valid, normal_x, normal_y, normal_z, zero_normal, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, zero_normal, output ready);
endinterface

// ===== hw/rtl/vertex_normal_smoothing.sv =====
// Vertex normal averaging: one item at a time through a controller and datapath.
// A load or an unused function code uses none of the arithmetic. A read or a triangle runs
// the normalizing shifts (up to 29), the bit-serial square root (31 steps) and the
// three-lane bit-serial divider (47 steps); a zero accumulator read skips them and a
// zero-area triangle ends before them. A read waits in its output state while the
// previous result is still held for transfer.
// Position and accumulator stores are single-port RAMs; a read of a never-loaded
// vertex returns unspecified data. No clearing pass is needed after reset.
// Depends on vns_pkg, vns_if, vns_ctrl, vns_datapath.
module vertex_normal_smoothing import vns_pkg::*; (
  input logic clk,
  input logic rst,
  vns_in_if.sink    in_ch,
  vns_out_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  vns_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd));

  vns_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_func(in_ch.func), .in_a(in_ch.vertex_a), .in_b(in_ch.vertex_b),
    .in_c(in_ch.vertex_c), .in_x(in_ch.pos_x), .in_y(in_ch.pos_y), .in_z(in_ch.pos_z),
    .nx(out_ch.normal_x), .ny(out_ch.normal_y), .nz(out_ch.normal_z),
    .nzero(out_ch.zero_normal));

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pos_wr && cmd.acc_wr)) else $error("two memory writes at once");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("second item taken");
endmodule

// ===== hw/rtl/vns_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module vns_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/vns_datapath.sv =====
// Datapath: position and accumulator memories, cross product, normalization
// (shift, squares, bit-serial square root, bit-serial divide). Uses vns_pkg, vns_ram.
module vns_datapath import vns_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [1:0]             in_func,
  input  logic [IdxW-1:0]        in_a,
  input  logic [IdxW-1:0]        in_b,
  input  logic [IdxW-1:0]        in_c,
  input  logic signed [PosW-1:0] in_x,
  input  logic signed [PosW-1:0] in_y,
  input  logic signed [PosW-1:0] in_z,
  output logic signed [NrmW-1:0] nx,
  output logic signed [NrmW-1:0] ny,
  output logic signed [NrmW-1:0] nz,
  output logic                   nzero
);
  func_t                  func;
  logic [IdxW-1:0]        ia, ib, ic;
  logic signed [PosW-1:0] lx, ly, lz;
  logic [IdxW-1:0]        addr;
  logic                   acc_we;
  logic [PosW-1:0]        prd [3];
  logic [AccW-1:0]        ard [3];
  logic [AccW-1:0]        awd [3];
  logic signed [PosW-1:0] pa [3], pb [3], pc [3];
  logic signed [EdgeW-1:0] u [3], w [3];
  logic signed [CrsW-1:0] crs [3];
  logic signed [CrsW-1:0] prod1 [3];
  logic [1:0]             acc_slot;
  logic [MagW-1:0]        mag [3];
  logic                   neg [3];
  logic [SumW-1:0]        sq [3];
  logic [SumW-1:0]        rem;
  logic [RootW-1:0]       root;
  logic [5:0]             rcnt;
  logic [QuoW-1:0]        quo [3];
  logic [5:0]             dcnt;
  logic signed [NrmW-1:0] q [3];
  logic [MagW-1:0]        mx;
  logic [CrsW-1:0]        cmag [3];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func <= func_t'(in_func);
      ia <= in_a; ib <= in_b; ic <= in_c;
      lx <= in_x; ly <= in_y; lz <= in_z;
    end
  end

  always_comb begin
    case (cmd.pos_sel)
      2'd1:    addr = ib;
      2'd2:    addr = ic;
      default: addr = ia;
    endcase
  end

  assign acc_we = cmd.pos_wr || cmd.acc_wr;

  function automatic logic [AccW-1:0] awd_sat(input logic [AccW-1:0] acc,
                                               input logic signed [NrmW-1:0] n);
    logic signed [AccW:0] s;
    s = $signed({acc[AccW-1], acc}) + (AccW+1)'(n);
    if (s > $signed({AccMax[AccW-1], AccMax})) return AccMax;
    if (s < $signed({AccMin[AccW-1], AccMin})) return AccMin;
    return s[AccW-1:0];
  endfunction

  for (genvar k = 0; k < 3; k++) begin : g_mem
    logic [PosW-1:0] pw;
    assign pw = (k == 0) ? lx : (k == 1) ? ly : lz;
    vns_ram #(.Width(PosW), .Depth(MaxVertices)) u_pos (
      .clk(clk), .we(cmd.pos_wr), .addr(addr), .wdata(pw), .rdata(prd[k]));
    assign awd[k] = cmd.pos_wr ? '0 : awd_sat(ard[k], q[k]);
    vns_ram #(.Width(AccW), .Depth(MaxVertices)) u_acc (
      .clk(clk), .we(acc_we), .addr(addr), .wdata(awd[k]), .rdata(ard[k]));
  end

  // Largest magnitude of the current vector, plus the magnitudes of the cross product.
  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    for (int k = 0; k < 3; k++) begin
      cmag[k] = crs[k][CrsW-1] ? CrsW'(-crs[k]) : CrsW'(crs[k]);
    end
  end

  // Edges are at most 25 bits, far below 2^30, so shrinking never fires here.
  assign sts.edge_big = 1'b0;

  // Coarse pre-shift for the wide cross product: bring it below 2^31 in one step.
  function automatic logic [5:0] cross_shift();
    logic [CrsW-1:0] m;
    logic [5:0] sh;
    m = cmag[0] | cmag[1] | cmag[2];
    sh = '0;
    for (int b = MagW; b < CrsW; b++) begin
      if (m[b]) sh = 6'(b - MagW + 1);
    end
    return sh;
  endfunction

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.latch_a) pa[k] <= prd[k];
      if (cmd.latch_b) pb[k] <= prd[k];
      if (cmd.latch_c) pc[k] <= prd[k];
      if (cmd.edge_form) begin
        u[k] <= EdgeW'(pb[k]) - EdgeW'(pa[k]);
        w[k] <= EdgeW'(pc[k]) - EdgeW'(pa[k]);
      end
    end
    if (cmd.cross1) begin
      prod1[0] <= CrsW'(u[1] * w[2]);
      prod1[1] <= CrsW'(u[2] * w[0]);
      prod1[2] <= CrsW'(u[0] * w[1]);
    end
    if (cmd.cross2) begin
      crs[0] <= prod1[0] - CrsW'(u[2] * w[1]);
      crs[1] <= prod1[1] - CrsW'(u[0] * w[2]);
      crs[2] <= prod1[2] - CrsW'(u[1] * w[0]);
    end
    if (cmd.acc_rd) begin
      acc_slot <= cmd.pos_sel;
    end
    if (cmd.split) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd.vec_from_acc) begin
          // Widen before negating so the most negative accumulator keeps its magnitude.
          neg[k] <= ard[k][AccW-1];
          mag[k] <= ard[k][AccW-1] ? MagW'(-(MagW'($signed(ard[k])))) : MagW'(ard[k]);
        end else begin
          neg[k] <= crs[k][CrsW-1];
          mag[k] <= MagW'(cmag[k] >> cross_shift());
        end
      end
    end
    // One shift step a cycle toward [2^29, 2^30).
    if (cmd.scale && !sts.scale_done) begin
      for (int k = 0; k < 3; k++) begin
        if (mx[MagW-1:MagW-2] != 2'b00) mag[k] <= mag[k] >> 1;
        else mag[k] <= mag[k] << 1;
      end
    end
    if (cmd.square) begin
      for (int k = 0; k < 3; k++) sq[k] <= SumW'(mag[k] * mag[k]);
    end
  end

  assign sts.vec_zero   = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  assign sts.scale_done = (mx[MagW-1:MagW-2] == 2'b01);
  assign sts.func       = func;
  assign sts.acc_slot   = acc_slot;

  // Remainder arithmetic keyed to the current bit position.
  logic [SumW+1:0] rwin, rtry;
  always_comb begin
    rwin = (SumW+2)'(rem >> (2 * (rcnt - 6'd1)));
    rtry = (SumW+2)'({root, 2'b01});
  end
  function automatic logic trial_ok();
    return rwin >= rtry;
  endfunction
  function automatic logic [SumW-1:0] rem_next_ok();
    return rem - SumW'(rtry << (2 * (rcnt - 6'd1)));
  endfunction

  // Bit-serial integer square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rem <= sq[0] + sq[1] + sq[2];
    end
    if (cmd.root_start) begin
      root <= '0;
      rcnt <= 6'(RootW);
    end else if (cmd.root_step) begin
      if (trial_ok()) begin
        root <= {root[RootW-2:0], 1'b1};
        rem  <= rem_next_ok();
      end else begin
        root <= {root[RootW-2:0], 1'b0};
      end
      rcnt <= rcnt - 6'd1;
    end
  end
  assign sts.root_done = (rcnt == 6'd0);

  // Restoring divider, three lanes sharing one counter: (mag*16384 + r/2) / r.
  logic [MagW+QuoW:0] dn [3];
  logic [RootW+1:0]   dr [3];
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      for (int k = 0; k < 3; k++) begin
        dn[k]  <= (MagW+QuoW+1)'({mag[k], 14'd0}) + (MagW+QuoW+1)'(root >> 1);
        dr[k]  <= '0;
        quo[k] <= '0;
      end
      dcnt <= 6'(MagW + QuoW + 1);
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        logic [RootW+1:0] t;
        t = {dr[k][RootW:0], dn[k][MagW+QuoW]};
        dn[k] <= {dn[k][MagW+QuoW-1:0], 1'b0};
        if (t >= (RootW+2)'(root)) begin
          dr[k]  <= t - (RootW+2)'(root);
          quo[k] <= {quo[k][QuoW-2:0], 1'b1};
        end else begin
          dr[k]  <= t;
          quo[k] <= {quo[k][QuoW-2:0], 1'b0};
        end
      end
      dcnt <= dcnt - 6'd1;
    end
  end
  assign sts.div_done = (dcnt == 6'd0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [NrmW-1:0] t;
      t = NrmW'(quo[k]);
      if (NrmW'(quo[k]) > OneQ14) t = OneQ14;
      q[k] = neg[k] ? -$signed(t) : $signed(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nzero <= 1'b0;
    end else if (cmd.out_load) begin
      nzero <= sts.vec_zero;
    end
    if (cmd.out_load) begin
      nx <= sts.vec_zero ? '0 : q[0];
      ny <= sts.vec_zero ? '0 : q[1];
      nz <= sts.vec_zero ? '0 : q[2];
    end
  end
endmodule

// ===== hw/rtl/vns_ctrl.sv =====
// Controller state machine sequencing the datapath for load, triangle and read.
// Uses vns_pkg.
module vns_ctrl import vns_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;
  logic [1:0] slot, slot_next;
  logic       ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      ov    <= ov_next;
    end
  end

  assign out_valid = ov;

  always_comb begin
    state_next = state;
    slot_next  = slot;
    ov_next    = ov && !out_ready;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_RD_A;
        end
      end
      ST_RD_A: begin
        case (sts.func)
          FUNC_LOAD: begin
            cmd.pos_wr = 1'b1;
            state_next = ST_IDLE;
          end
          FUNC_TRI: begin
            cmd.pos_sel = 2'd0;
            state_next  = ST_RD_B;
          end
          FUNC_READ: begin
            cmd.pos_sel = 2'd0;
            state_next  = ST_ACC_LAT;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_RD_B: begin
        cmd.latch_a = 1'b1;
        cmd.pos_sel = 2'd1;
        state_next  = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.latch_b = 1'b1;
        cmd.pos_sel = 2'd2;
        state_next  = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.latch_c = 1'b1;
        state_next  = ST_SHRINK;
      end
      ST_SHRINK: begin
        cmd.edge_form = 1'b1;
        state_next    = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.cross1 = 1'b1;
        state_next = ST_CROSS2;
      end
      ST_CROSS2: begin
        cmd.cross2 = 1'b1;
        state_next = ST_SPLIT;
      end
      ST_ACC_LAT: begin
        cmd.vec_from_acc = 1'b1;
        cmd.split        = 1'b1;
        state_next       = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (sts.func == FUNC_TRI) begin
          cmd.split = 1'b1;
        end
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (sts.vec_zero) begin
          if (sts.func == FUNC_READ) state_next = ST_OUT;
          else state_next = ST_IDLE;
        end else begin
          cmd.scale = 1'b1;
          if (sts.scale_done) state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum        = 1'b1;
        cmd.root_start = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) begin
          cmd.root_step = 1'b0;
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_step = 1'b0;
          slot_next    = '0;
          if (sts.func == FUNC_READ) state_next = ST_OUT;
          else state_next = ST_ACC_RD;
        end
      end
      ST_ACC_RD: begin
        cmd.pos_sel = slot;
        cmd.acc_rd  = 1'b1;
        state_next  = ST_ACC_UPD;
      end
      ST_ACC_UPD: begin
        cmd.pos_sel = slot;
        state_next  = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd.pos_sel = slot;
        cmd.acc_wr  = 1'b1;
        if (slot == 2'd2) begin
          state_next = ST_IDLE;
        end else begin
          slot_next  = slot + 2'd1;
          state_next = ST_ACC_RD;
        end
      end
      ST_OUT: begin
        if (!ov || out_ready) begin
          cmd.out_load = 1'b1;
          ov_next      = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for vertex_normal_smoothing: directed table, then random items.
// Depends on vns_pkg and the vns_in_if / vns_out_if channel interfaces of the RTL.
module testbench;
  import vns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];

  typedef struct {
    func_t                  func;
    logic [IdxW-1:0]        va;
    logic [IdxW-1:0]        vb;
    logic [IdxW-1:0]        vc;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] pz;
    bit                     typed;
    logic signed [NrmW-1:0] nx;
    logic signed [NrmW-1:0] ny;
    logic signed [NrmW-1:0] nz;
    bit                     zf;
  } stim_t;

  typedef struct {
    logic signed [NrmW-1:0] nx;
    logic signed [NrmW-1:0] ny;
    logic signed [NrmW-1:0] nz;
    logic                   zf;
  } normal_t;

  localparam logic signed [PosW-1:0] PMax = 24'sh7FFFFF;
  localparam logic signed [PosW-1:0] PMin = 24'sh800000;
  localparam logic signed [NrmW-1:0] One = 16'sd16384;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vns_in_if  in_ch (clk);
  vns_out_if out_ch (clk);

  vertex_normal_smoothing uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the vertex store and the normal accumulators.
  longint  pos_mem [3][MaxVertices];
  longint  acc_mem [3][MaxVertices];
  bit      loaded [MaxVertices];
  normal_t normals_due [$];
  int      errors = 0;
  bit      calm = 1'b0;

  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void shrink_edge(inout vec3_t v);
    longint unsigned mag [3];
    longint unsigned mx;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) v[i] = (v[i] < 0) ? -longint'(mag[i]) : longint'(mag[i]);
  endfunction

  // Scales a vector to unit length in Q1.14; returns 0 for the zero vector.
  function automatic bit unit_normal(input vec3_t v, output vec3_t q);
    longint unsigned mag [3];
    bit              neg [3];
    longint unsigned mx, s, r, t;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > mx) mx = mag[i];
      q[i] = 0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      t = (mag[i] * 16384 + r / 2) / r;
      if (t > 16384) t = 16384;
      q[i] = neg[i] ? -longint'(t) : longint'(t);
    end
    return 1'b1;
  endfunction

  function automatic void add_sat(input int k, input int idx, input longint n);
    longint x;
    x = acc_mem[k][idx] + n;
    if (x > 33554431) x = 33554431;
    if (x < -33554432) x = -33554432;
    acc_mem[k][idx] = x;
  endfunction

  // Applies one accepted item to the mirror; returns 1 when a normal comes out.
  function automatic bit smooth_step(input stim_t s, output normal_t n);
    vec3_t u, w, c, q;
    bit    nz;
    n = '{0, 0, 0, 0};
    case (s.func)
      FUNC_LOAD: begin
        pos_mem[0][s.va] = longint'(s.px);
        pos_mem[1][s.va] = longint'(s.py);
        pos_mem[2][s.va] = longint'(s.pz);
        for (int k = 0; k < 3; k++) acc_mem[k][s.va] = 0;
        return 1'b0;
      end
      FUNC_TRI: begin
        for (int k = 0; k < 3; k++) begin
          u[k] = pos_mem[k][s.vb] - pos_mem[k][s.va];
          w[k] = pos_mem[k][s.vc] - pos_mem[k][s.va];
        end
        shrink_edge(u);
        shrink_edge(w);
        c[0] = u[1] * w[2] - u[2] * w[1];
        c[1] = u[2] * w[0] - u[0] * w[2];
        c[2] = u[0] * w[1] - u[1] * w[0];
        if (unit_normal(c, q)) begin
          for (int k = 0; k < 3; k++) begin
            add_sat(k, int'(s.va), q[k]);
            add_sat(k, int'(s.vb), q[k]);
            add_sat(k, int'(s.vc), q[k]);
          end
        end
        return 1'b0;
      end
      FUNC_READ: begin
        for (int k = 0; k < 3; k++) u[k] = acc_mem[k][s.va];
        nz = unit_normal(u, q);
        n.nx = NrmW'(q[0]);
        n.ny = NrmW'(q[1]);
        n.nz = NrmW'(q[2]);
        n.zf = !nz;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input stim_t s);
    normal_t n;
    int      g;
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.func     = s.func;
    in_ch.vertex_a = s.va;
    in_ch.vertex_b = s.vb;
    in_ch.vertex_c = s.vc;
    in_ch.pos_x    = s.px;
    in_ch.pos_y    = s.py;
    in_ch.pos_z    = s.pz;
    do @(posedge clk); while (!in_ch.ready);
    if (smooth_step(s, n)) begin
      if (s.typed) normals_due.push_back('{s.nx, s.ny, s.nz, s.zf});
      else normals_due.push_back(n);
    end
    if (s.func == FUNC_LOAD) loaded[s.va] = 1'b1;
    g = idle_len();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  function automatic stim_t mk(input func_t f, input int a, input int b, input int c,
                               input logic signed [PosW-1:0] x, input logic signed [PosW-1:0] y,
                               input logic signed [PosW-1:0] z);
    stim_t s;
    s = '{f, IdxW'(a), IdxW'(b), IdxW'(c), x, y, z, 1'b0, 0, 0, 0, 1'b0};
    return s;
  endfunction

  function automatic stim_t with_normal(input stim_t s, input logic signed [NrmW-1:0] x,
                                        input logic signed [NrmW-1:0] y,
                                        input logic signed [NrmW-1:0] z, input bit zf);
    s.typed = 1'b1;
    s.nx = x;
    s.ny = y;
    s.nz = z;
    s.zf = zf;
    return s;
  endfunction

  function automatic logic signed [PosW-1:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return PosW'($urandom);
      1: return PosW'($signed($urandom_range(0, 8191)) - 4096);
      2: return ($urandom_range(0, 1)) ? PMax : PMin;
      default: return PosW'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  // Ready side: random stalls, mostly short, a few long, none while calm.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst || calm) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if ($urandom_range(0, 99) < 30) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    normal_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (normals_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected normal transfer at %0t", $realtime);
      end else begin
        e = normals_due.pop_front();
        if (out_ch.normal_x !== e.nx || out_ch.normal_y !== e.ny ||
            out_ch.normal_z !== e.nz || out_ch.zero_normal !== e.zf) begin
          errors++;
          if (errors <= 10)
            $display("normal mismatch: expected %0d %0d %0d z%0d, got %0d %0d %0d z%0d",
                     e.nx, e.ny, e.nz, e.zf, out_ch.normal_x, out_ch.normal_y,
                     out_ch.normal_z, out_ch.zero_normal);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("vertex_normal_smoothing verification failed");
    $finish;
  end

  initial begin
    stim_t directed [$];
    stim_t s;
    int    pool [24];
    int    a, b, c, r;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    in_ch.vertex_c = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b1;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < MaxVertices; i++) begin
        pos_mem[k][i] = 0;
        acc_mem[k][i] = 0;
      end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = '{
      mk(FUNC_LOAD, 0, 0, 0, 0, 0, 0),
      mk(FUNC_LOAD, 1, 1023, 1023, PMax, 0, 0),
      mk(FUNC_LOAD, 2, 0, 0, 0, PMax, 0),
      mk(FUNC_LOAD, 1023, 0, 0, PMin, PMin, PMin),
      with_normal(mk(FUNC_READ, 0, 1023, 1023, PMax, PMax, PMax), 0, 0, 0, 1'b1),
      mk(FUNC_TRI, 0, 1, 2, 0, 0, 0),
      with_normal(mk(FUNC_READ, 0, 0, 0, 0, 0, 0), 0, 0, One, 1'b0),
      with_normal(mk(FUNC_READ, 1, 0, 0, 0, 0, 0), 0, 0, One, 1'b0),
      mk(FUNC_TRI, 0, 0, 1, 0, 0, 0),
      with_normal(mk(FUNC_READ, 0, 0, 0, 0, 0, 0), 0, 0, One, 1'b0),
      mk(FUNC_LOAD, 3, 0, 0, PMin, PMax, PMin),
      mk(FUNC_TRI, 1023, 1, 3, 0, 0, 0),
      mk(FUNC_READ, 1023, 0, 0, 0, 0, 0),
      mk(FUNC_NONE, 1023, 1023, 1023, -1, -1, -1),
      mk(FUNC_READ, 3, 0, 0, 0, 0, 0),
      mk(FUNC_LOAD, 1, 0, 0, PMax, 0, 0),
      with_normal(mk(FUNC_READ, 1, 0, 0, 0, 0, 0), 0, 0, 0, 1'b1),
      mk(FUNC_TRI, 0, 2, 1, 0, 0, 0),
      mk(FUNC_READ, 2, 0, 0, 0, 0, 0),
      mk(FUNC_TRI, 3, 3, 3, 0, 0, 0),
      mk(FUNC_READ, 0, 0, 0, 0, 0, 0)
    };
    foreach (directed[i]) send_item(directed[i]);

    for (int i = 0; i < 1600; i++) begin
      if (i % 400 == 0)
        foreach (pool[j]) pool[j] = $urandom_range(0, MaxVertices - 1);
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      s = mk(FUNC_LOAD, pool[$urandom_range(0, 23)], $urandom_range(0, 1023),
             $urandom_range(0, 1023), rand_pos(), rand_pos(), rand_pos());
      r = $urandom_range(0, 99);
      a = pool[$urandom_range(0, 23)];
      b = pool[$urandom_range(0, 23)];
      c = pool[$urandom_range(0, 23)];
      if (r < 5) begin
        s.func = FUNC_NONE;
      end else if (r < 30 || !(loaded[a] && loaded[b] && loaded[c])) begin
        // Now and then a vertex lands on another one, giving a degenerate face.
        if ($urandom_range(0, 9) == 0 && loaded[b]) begin
          s.px = PosW'(pos_mem[0][b]);
          s.py = PosW'(pos_mem[1][b]);
          s.pz = PosW'(pos_mem[2][b]);
        end
      end else if (r < 70) begin
        s.func = FUNC_TRI;
        s.va = IdxW'(a);
        s.vb = IdxW'(b);
        s.vc = IdxW'(c);
      end else begin
        s.func = FUNC_READ;
        s.va = IdxW'(a);
      end
      send_item(s);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (normals_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && normals_due.size() == 0)
      $display("vertex_normal_smoothing verification clean");
    else
      $display("vertex_normal_smoothing verification failed");
    $finish;
  end

endmodule
